[sv/pnl_pkg.sv]
// Shared types, constants and helper functions of the pixel normalizer.
// Used by the interfaces and every module of the block; depends on nothing.

package pnl_pkg;

    localparam int DIM_W    = 13;
    localparam int PC_W     = 24;
    localparam int SIZE_W   = 25;
    localparam int IDX_W    = 26;
    localparam int VAL_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIM_W-1:0] MAX_WIDTH  = 13'd4096;
    localparam logic [DIM_W-1:0] MAX_HEIGHT = 13'd4096;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANAR_LAYOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_VALUE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_VALUE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd7;

    // Source byte orders.
    localparam logic [2:0] FMT_RGB  = 3'd0;
    localparam logic [2:0] FMT_RGBA = 3'd1;
    localparam logic [2:0] FMT_BGRA = 3'd2;
    localparam logic [2:0] FMT_ARGB = 3'd3;
    localparam logic [2:0] FMT_ABGR = 3'd4;
    localparam logic [2:0] FMT_BGR  = 3'd5;

    localparam logic MODE_BYTE  = 1'b0;
    localparam logic MODE_FIXED = 1'b1;

    localparam logic [VAL_W-1:0] VAL_POS_SAT  = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_NEG_SAT  = 32'h8000_0000;
    localparam logic [VAL_W-1:0] VAL_BYTE_ERR = 32'h0000_00FF;

    typedef struct packed {
        logic [2:0]            source_format;
        logic                  planar_layout;
        logic                  element_mode;
        logic signed [15:0]    offset_value;
        logic [15:0]           scale_value;
        logic [DIM_W-1:0]      frame_width;
        logic [DIM_W-1:0]      frame_height;
        logic [1:0]            channel_count;
    } pnl_cfg_t;

    // One pixel as it waits between the front and the back part.
    typedef struct packed {
        logic [2:0][7:0]       chan_bytes;
        logic [PC_W-1:0]       pc;
        logic                  frame_end;
    } pnl_entry_t;

    // Which source byte holds channel k for a given byte order.
    function automatic logic [1:0] chan_byte_sel(input logic [2:0] fmt, input logic [1:0] k);
        logic [1:0] sel;
        begin
            case (fmt)
                FMT_BGRA, FMT_BGR: sel = 2'd2 - k;
                FMT_ARGB:          sel = k + 2'd1;
                FMT_ABGR:          sel = 2'd3 - k;
                default:           sel = k;
            endcase
            return sel;
        end
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        begin
            if (v == '0)
                r = {{(DIM_W-1){1'b0}}, 1'b1};
            else if (v > maxv)
                r = maxv;
            else
                r = v;
            return r;
        end
    endfunction

endpackage

[sv/pnl_if.sv]
// Handshake channels of the pixel normalizer: pixel input, result output
// and configuration write. Depends on pnl_pkg.

interface pnl_pixel_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_bytes;

    modport source (output valid, output pixel_bytes, input ready);
    modport sink   (input valid, input pixel_bytes, output ready);
endinterface

interface pnl_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [pnl_pkg::VAL_W-1:0]  out_value;
    logic [pnl_pkg::IDX_W-1:0]         tensor_index;
    logic [1:0]                        channel_number;
    logic                              last_of_pixel;
    logic                              last_of_frame;
    logic                              divide_error;

    modport source (output valid, output out_value, output tensor_index,
                    output channel_number, output last_of_pixel,
                    output last_of_frame, output divide_error, input ready);
    modport sink   (input valid, input out_value, input tensor_index,
                    input channel_number, input last_of_pixel,
                    input last_of_frame, input divide_error, output ready);
endinterface

interface pnl_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [pnl_pkg::CFG_IDX_W-1:0]       index;
    logic [pnl_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/pixel_normalize_layout.sv]
// Top level of the pixel normalizer: configuration registers, frame size,
// and the front part, queue and back part. Depends on pnl_pkg and pnl_if.

// Each accepted pixel yields one result item per channel (one to three),
// holding (byte + offset) / scale and the element's HWC or CHW tensor index.
// The channel results share one divider that retires four quotient bits per
// cycle; each channel goes through set-up, nine divide steps and hand-off
// once its pixel reaches the back part; a two-entry queue lets the next
// pixels be taken in meanwhile, and the output register lets the next
// division run while a result waits.
// Configuration writes are always accepted; no pixel is taken in the cycle
// right after a write, while the frame size is recomputed.

module pixel_normalize_layout (
    input  logic           clk,
    input  logic           rst_n,
    pnl_pixel_if.sink      pixel,
    pnl_result_if.source   result,
    pnl_cfg_if.sink        cfg
);

    pnl_pkg::pnl_cfg_t              cfg_reg, cfg_next;
    logic                           cfg_recent_reg;
    logic [pnl_pkg::SIZE_W-1:0]     size_reg;
    logic [pnl_pkg::DIM_W-1:0]      w_clamped, h_clamped;
    logic [2*pnl_pkg::DIM_W-1:0]    size_prod;
    logic                           cfg_write;

    logic                           push, pop, queue_full, queue_not_empty;
    pnl_pkg::pnl_entry_t            push_entry, head_entry;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg.index)
                pnl_pkg::REG_SOURCE_FORMAT: cfg_next.source_format = cfg.data[2:0];
                pnl_pkg::REG_PLANAR_LAYOUT: cfg_next.planar_layout = cfg.data[0];
                pnl_pkg::REG_ELEMENT_MODE:  cfg_next.element_mode  = cfg.data[0];
                pnl_pkg::REG_OFFSET_VALUE:  cfg_next.offset_value  = cfg.data;
                pnl_pkg::REG_SCALE_VALUE:   cfg_next.scale_value   = cfg.data;
                pnl_pkg::REG_FRAME_WIDTH:
                    cfg_next.frame_width = cfg.data[pnl_pkg::DIM_W-1:0];
                pnl_pkg::REG_FRAME_HEIGHT:
                    cfg_next.frame_height = cfg.data[pnl_pkg::DIM_W-1:0];
                pnl_pkg::REG_CHANNEL_COUNT: cfg_next.channel_count = cfg.data[1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    assign w_clamped = pnl_pkg::clamp_dim(cfg_reg.frame_width, pnl_pkg::MAX_WIDTH);
    assign h_clamped = pnl_pkg::clamp_dim(cfg_reg.frame_height, pnl_pkg::MAX_HEIGHT);
    assign size_prod = w_clamped * h_clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_format <= pnl_pkg::FMT_RGB;
            cfg_reg.planar_layout <= 1'b0;
            cfg_reg.element_mode  <= pnl_pkg::MODE_BYTE;
            cfg_reg.offset_value  <= 16'sd0;
            cfg_reg.scale_value   <= 16'd256;
            cfg_reg.frame_width   <= 13'd1;
            cfg_reg.frame_height  <= 13'd1;
            cfg_reg.channel_count <= 2'd3;
            cfg_recent_reg        <= 1'b0;
            size_reg              <= 25'd1;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            cfg_recent_reg <= cfg_write;
            size_reg       <= size_prod[pnl_pkg::SIZE_W-1:0];
        end
    end

    pnl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .cfg_val    (cfg_reg),
        .frame_size (size_reg),
        .hold       (cfg_recent_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    pnl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_entry (head_entry),
        .not_empty  (queue_not_empty)
    );

    pnl_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_val         (cfg_reg),
        .frame_size      (size_reg),
        .head_entry      (head_entry),
        .queue_not_empty (queue_not_empty),
        .pop             (pop),
        .result          (result)
    );

endmodule

[sv/pnl_queue.sv]
// Two-entry queue that decouples pixel intake from the channel arithmetic.
// Depends on pnl_pkg for the entry type.

module pnl_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pnl_pkg::pnl_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output pnl_pkg::pnl_entry_t head_entry,
    output logic                not_empty
);

    pnl_pkg::pnl_entry_t slot_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign not_empty  = (count_reg != 2'd0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[sv/pnl_front.sv]
// Front part: accepts pixels, picks the R, G and B bytes, tracks the frame
// position and queues the pixel. Depends on pnl_pkg and pnl_if.

module pnl_front (
    input  logic                          clk,
    input  logic                          rst_n,
    pnl_pixel_if.sink                     pixel,
    input  pnl_pkg::pnl_cfg_t             cfg_val,
    input  logic [pnl_pkg::SIZE_W-1:0]    frame_size,
    input  logic                          hold,
    input  logic                          queue_full,
    output logic                          push,
    output pnl_pkg::pnl_entry_t           push_entry
);

    logic [pnl_pkg::PC_W-1:0]   pc_reg, pc_next;
    logic [pnl_pkg::SIZE_W-1:0] pc_plus;
    logic                       frame_end;
    logic [1:0]                 sel [0:2];

    assign pixel.ready = !queue_full && !hold;
    assign push        = pixel.valid && pixel.ready;

    // A pixel at or past the last position closes the frame.
    assign pc_plus   = {1'b0, pc_reg} + {{(pnl_pkg::SIZE_W-1){1'b0}}, 1'b1};
    assign frame_end = (pc_plus >= frame_size);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sel[k] = pnl_pkg::chan_byte_sel(cfg_val.source_format, 2'(k));
            case (sel[k])
                2'd0:    push_entry.chan_bytes[k] = pixel.pixel_bytes[7:0];
                2'd1:    push_entry.chan_bytes[k] = pixel.pixel_bytes[15:8];
                2'd2:    push_entry.chan_bytes[k] = pixel.pixel_bytes[23:16];
                default: push_entry.chan_bytes[k] = pixel.pixel_bytes[31:24];
            endcase
        end
        push_entry.pc        = pc_reg;
        push_entry.frame_end = frame_end;
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (push)
        begin
            pc_next = frame_end ? '0 : pc_plus[pnl_pkg::PC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

[sv/pnl_back.sv]
// Back part: for each channel of a queued pixel forms dividend and divisor,
// runs a shared radix-16 restoring divider and emits the result item.
// Depends on pnl_pkg and pnl_if.

module pnl_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pnl_pkg::pnl_cfg_t             cfg_val,
    input  logic [pnl_pkg::SIZE_W-1:0]    frame_size,
    input  pnl_pkg::pnl_entry_t           head_entry,
    input  logic                          queue_not_empty,
    output logic                          pop,
    pnl_result_if.source                  result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam int QUO_W      = 36;
    localparam int DIV_STEPS  = 9;
    localparam int BITS_STEP  = 4;

    logic [1:0]                  state_reg, state_next;
    pnl_pkg::pnl_entry_t         entry_reg, entry_next;
    logic [1:0]                  ch_reg, ch_next;
    logic [3:0]                  cnt_reg, cnt_next;
    logic [QUO_W-1:0]            quo_reg, quo_next;
    logic [15:0]                 rem_reg, rem_next;
    logic [15:0]                 dvs_reg, dvs_next;
    logic                        neg_reg, neg_next;
    logic                        err_reg, err_next;
    logic [pnl_pkg::IDX_W-1:0]   idx_reg, idx_next;

    logic                        out_valid_reg, out_valid_next;
    logic [pnl_pkg::VAL_W-1:0]   out_value_reg, out_value_next;
    logic [pnl_pkg::IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic [1:0]                  out_ch_reg, out_ch_next;
    logic                        out_lastp_reg, out_lastp_next;
    logic                        out_lastf_reg, out_lastf_next;
    logic                        out_err_reg, out_err_next;

    logic [1:0]                  nch;
    logic                        last_ch;
    logic [7:0]                  cur_byte;
    logic [16:0]                 off_ext, off_abs;
    logic [7:0]                  k_mag, k_off, t_byte;
    logic [17:0]                 s_val;
    logic [16:0]                 s_mag;
    logic [pnl_pkg::IDX_W-1:0]   idx_hwc, idx_chw;
    logic [15:0]                 r_step;
    logic [16:0]                 r_wide;
    logic [QUO_W-1:0]            q_step;
    logic                        q_over;
    logic [pnl_pkg::VAL_W-1:0]   val_fin;

    assign nch     = (cfg_val.channel_count == 2'd0) ? 2'd1 : cfg_val.channel_count;
    assign last_ch = (ch_reg + 2'd1 == nch);

    always_comb
    begin
        case (ch_reg)
            2'd0:    cur_byte = entry_reg.chan_bytes[0];
            2'd1:    cur_byte = entry_reg.chan_bytes[1];
            default: cur_byte = entry_reg.chan_bytes[2];
        endcase
    end

    // Byte mode adds the offset's integer part, truncated toward zero.
    assign off_ext = {cfg_val.offset_value[15], cfg_val.offset_value};
    assign off_abs = cfg_val.offset_value[15] ? (17'd0 - off_ext) : off_ext;
    assign k_mag   = off_abs[15:8] | {off_abs[16], 7'd0};
    assign k_off   = cfg_val.offset_value[15] ? (8'd0 - k_mag) : k_mag;
    assign t_byte  = cur_byte + k_off;

    // Fixed mode works on the exact signed Q10.8 sum.
    assign s_val = {2'b00, cur_byte, 8'd0} + {{2{cfg_val.offset_value[15]}}, cfg_val.offset_value};
    assign s_mag = s_val[17] ? 17'(18'd0 - s_val) : s_val[16:0];

    assign idx_hwc = {2'b00, entry_reg.pc} * {{(pnl_pkg::IDX_W-2){1'b0}}, nch}
                     + {{(pnl_pkg::IDX_W-2){1'b0}}, ch_reg};
    assign idx_chw = {1'b0, frame_size} * {{(pnl_pkg::IDX_W-2){1'b0}}, ch_reg}
                     + {2'b00, entry_reg.pc};

    // Four quotient bits per cycle.
    always_comb
    begin
        r_step = rem_reg;
        q_step = quo_reg;
        r_wide = '0;
        for (int i = 0; i < BITS_STEP; i++)
        begin
            r_wide = {r_step, q_step[QUO_W-1]};
            q_step = {q_step[QUO_W-2:0], 1'b0};
            if (r_wide >= {1'b0, dvs_reg})
            begin
                r_wide    = r_wide - {1'b0, dvs_reg};
                q_step[0] = 1'b1;
            end
            r_step = r_wide[15:0];
        end
    end

    assign q_over = (quo_reg[QUO_W-1:31] != '0);

    always_comb
    begin
        if (cfg_val.element_mode == pnl_pkg::MODE_BYTE)
        begin
            val_fin = err_reg ? pnl_pkg::VAL_BYTE_ERR : {24'd0, quo_reg[7:0]};
        end
        else if (err_reg || q_over)
        begin
            val_fin = neg_reg ? pnl_pkg::VAL_NEG_SAT : pnl_pkg::VAL_POS_SAT;
        end
        else
        begin
            val_fin = neg_reg ? (32'd0 - quo_reg[31:0]) : quo_reg[31:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        entry_next     = entry_reg;
        ch_next        = ch_reg;
        cnt_next       = cnt_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        neg_next       = neg_reg;
        err_next       = err_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_idx_next   = out_idx_reg;
        out_ch_next    = out_ch_reg;
        out_lastp_next = out_lastp_reg;
        out_lastf_next = out_lastf_reg;
        out_err_next   = out_err_reg;
        pop            = 1'b0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (queue_not_empty)
                begin
                    pop        = 1'b1;
                    entry_next = head_entry;
                    ch_next    = 2'd0;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                rem_next = '0;
                cnt_next = '0;
                if (cfg_val.element_mode == pnl_pkg::MODE_BYTE)
                begin
                    quo_next = {28'd0, t_byte};
                    dvs_next = {8'd0, cfg_val.scale_value[15:8]};
                    neg_next = 1'b0;
                    err_next = (cfg_val.scale_value[15:8] == 8'd0);
                end
                else
                begin
                    quo_next = {3'd0, s_mag, 16'd0};
                    dvs_next = cfg_val.scale_value;
                    neg_next = s_val[17];
                    err_next = (cfg_val.scale_value == 16'd0);
                end
                idx_next   = cfg_val.planar_layout ? idx_chw : idx_hwc;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                quo_next = q_step;
                rem_next = r_step;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = val_fin;
                    out_idx_next   = idx_reg;
                    out_ch_next    = ch_reg;
                    out_lastp_next = last_ch;
                    out_lastf_next = last_ch && entry_reg.frame_end;
                    out_err_next   = err_reg;
                    if (last_ch)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = ST_PREP;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            ch_reg        <= 2'd0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ch_reg        <= ch_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg     <= entry_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        dvs_reg       <= dvs_next;
        neg_reg       <= neg_next;
        err_reg       <= err_next;
        idx_reg       <= idx_next;
        out_value_reg <= out_value_next;
        out_idx_reg   <= out_idx_next;
        out_ch_reg    <= out_ch_next;
        out_lastp_reg <= out_lastp_next;
        out_lastf_reg <= out_lastf_next;
        out_err_reg   <= out_err_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.out_value      = out_value_reg;
    assign result.tensor_index   = out_idx_reg;
    assign result.channel_number = out_ch_reg;
    assign result.last_of_pixel  = out_lastp_reg;
    assign result.last_of_frame  = out_lastf_reg;
    assign result.divide_error   = out_err_reg;

endmodule
